FILE: design/advrid_pkg.sv
`default_nettype none
package advrid_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] SVC_UUID   = 16'hFFFA;
    localparam logic [15:0] MFR_ID     = 16'h0200;
    localparam logic [7:0]  RID_APP_ID = 8'h0D;
    localparam logic [7:0]  TYPE_SVC16 = 8'h16;
    localparam logic [7:0]  TYPE_MFG   = 8'hFF;
    localparam logic [7:0]  MIN_ADV    = 8'd6;

    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_STREAM = 2'd1;
    localparam logic [1:0] PH_FOUND  = 2'd2;
    localparam logic [1:0] PH_STOP   = 2'd3;

    localparam logic KIND_PAY = 1'b0;
    localparam logic KIND_SUM = 1'b1;

    // one queue entry: optional payload byte, optional summary
    typedef struct packed {
        logic               has_pay;
        logic [7:0]         pay_byte;
        logic               pay_last;
        logic               has_sum;
        logic               found;
        logic               ext;
        logic [47:0]        addr;
        logic signed [7:0]  rssi;
        logic [7:0]         plen;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

FILE: design/advrid_front.sv
`default_nettype none
module advrid_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_accept,
    input  wire [7:0]               i_data_byte,
    input  wire                     i_start_of_adv,
    input  wire [7:0]               i_adv_length,
    input  wire                     i_is_extended,
    input  wire [47:0]              i_device_address,
    input  wire signed [7:0]        i_signal_strength,
    output logic                    o_push,
    output advrid_pkg::t_rec        o_rec
);

    logic [7:0] r_pos, n_pos;
    logic [8:0] r_nfs, n_nfs;
    logic [7:0] r_flen, n_flen;
    logic [7:0] r_ftype, n_ftype;
    logic [7:0] r_idlo, n_idlo;
    logic [1:0] r_phase, n_phase;
    logic [7:0] r_mlen, n_mlen;

    logic [7:0]  p;
    logic [8:0]  p9, b9, len9, rel;
    logic [15:0] id;
    logic        fin, active, cand, has_pay, last;

    always_comb begin
        p       = i_start_of_adv ? 8'd0 : r_pos;
        n_nfs   = i_start_of_adv ? 9'd0 : r_nfs;
        n_flen  = i_start_of_adv ? 8'd0 : r_flen;
        n_ftype = i_start_of_adv ? 8'd0 : r_ftype;
        n_idlo  = i_start_of_adv ? 8'd0 : r_idlo;
        n_phase = i_start_of_adv ? advrid_pkg::PH_SEARCH : r_phase;
        n_mlen  = i_start_of_adv ? 8'd0 : r_mlen;

        p9      = {1'b0, p};
        b9      = {1'b0, i_data_byte};
        len9    = {1'b0, i_adv_length};
        fin     = (i_adv_length == 8'd0) || (p9 + 9'd1 >= len9);
        active  = (i_adv_length >= advrid_pkg::MIN_ADV) &&
                  (n_phase != advrid_pkg::PH_STOP) && (n_phase != advrid_pkg::PH_FOUND);
        rel     = p9 - (n_nfs - {1'b0, n_flen} - 9'd1);
        id      = {i_data_byte, n_idlo};
        cand    = (n_flen >= 8'd4) &&
                  (((n_ftype == advrid_pkg::TYPE_SVC16) && (id == advrid_pkg::SVC_UUID)) ||
                   ((n_ftype == advrid_pkg::TYPE_MFG) && (id == advrid_pkg::MFR_ID)));
        has_pay = 1'b0;
        last    = 1'b0;

        if (active) begin
            if ((n_phase == advrid_pkg::PH_SEARCH) && (p9 == n_nfs)) begin
                if (p9 + 9'd1 < len9) begin
                    if ((i_data_byte == 8'd0) || (p9 + b9 >= len9)) begin
                        n_phase = advrid_pkg::PH_STOP;
                    end else begin
                        n_flen = i_data_byte;
                        n_nfs  = p9 + b9 + 9'd1;
                    end
                end
            end else if (p9 < n_nfs) begin
                if (n_phase == advrid_pkg::PH_SEARCH) begin
                    if (rel == 9'd1) begin
                        n_ftype = i_data_byte;
                    end else if (rel == 9'd2) begin
                        n_idlo = i_data_byte;
                    end else if (rel == 9'd3) begin
                        if (!cand) begin
                            n_ftype = 8'd0;
                        end
                    end else if (rel == 9'd4) begin
                        if ((n_ftype != 8'd0) && (n_flen >= 8'd5) &&
                            (i_data_byte == advrid_pkg::RID_APP_ID)) begin
                            n_mlen  = n_flen - 8'd5;
                            n_phase = (n_mlen != 8'd0) ? advrid_pkg::PH_STREAM
                                                       : advrid_pkg::PH_FOUND;
                        end
                    end
                end else if ((rel >= 9'd6) && (rel <= {1'b0, n_flen})) begin
                    has_pay = 1'b1;
                    last    = (rel == {1'b0, n_flen});
                    if (last) begin
                        n_phase = advrid_pkg::PH_FOUND;
                    end
                end
            end
        end

        o_rec.has_pay  = has_pay;
        o_rec.pay_byte = i_data_byte;
        o_rec.pay_last = last;
        o_rec.has_sum  = fin;
        o_rec.found    = (i_adv_length >= advrid_pkg::MIN_ADV) &&
                         ((n_phase == advrid_pkg::PH_STREAM) ||
                          (n_phase == advrid_pkg::PH_FOUND));
        o_rec.ext      = i_is_extended;
        o_rec.addr     = i_device_address;
        o_rec.rssi     = i_signal_strength;
        o_rec.plen     = o_rec.found ? n_mlen : 8'd0;
        o_push         = i_accept && (has_pay || fin);

        n_pos = p + 8'd1;
        if (fin) begin
            n_pos   = 8'd0;
            n_nfs   = 9'd0;
            n_flen  = 8'd0;
            n_ftype = 8'd0;
            n_idlo  = 8'd0;
            n_phase = advrid_pkg::PH_SEARCH;
            n_mlen  = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 8'd0;
            r_nfs   <= 9'd0;
            r_flen  <= 8'd0;
            r_ftype <= 8'd0;
            r_idlo  <= 8'd0;
            r_phase <= advrid_pkg::PH_SEARCH;
            r_mlen  <= 8'd0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_nfs   <= n_nfs;
            r_flen  <= n_flen;
            r_ftype <= n_ftype;
            r_idlo  <= n_idlo;
            r_phase <= n_phase;
            r_mlen  <= n_mlen;
        end
    end

endmodule
`default_nettype wire

FILE: design/advrid_queue.sv
`default_nettype none
module advrid_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  advrid_pkg::t_rec        i_rec,
    input  wire                     i_pop,
    output advrid_pkg::t_rec        o_head,
    output advrid_pkg::t_q_stat     o_stat
);

    localparam logic [advrid_pkg::QPTR_W-1:0] PTR_LAST =
        advrid_pkg::QPTR_W'(advrid_pkg::QUEUE_DEPTH - 1);
    localparam logic [advrid_pkg::QCNT_W-1:0] CNT_FULL =
        advrid_pkg::QCNT_W'(advrid_pkg::QUEUE_DEPTH);

    advrid_pkg::t_rec r_mem [advrid_pkg::QUEUE_DEPTH];
    logic [advrid_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [advrid_pkg::QCNT_W-1:0] r_count;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full && !i_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: design/advrid_back.sv
`default_nettype none
module advrid_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  advrid_pkg::t_rec        i_head,
    input  advrid_pkg::t_q_stat     i_q_stat,
    output logic                    o_pop,
    input  wire                     i_stall,
    output logic                    o_valid,
    output logic                    o_kind,
    output logic [7:0]              o_payload_byte,
    output logic                    o_payload_last,
    output logic                    o_found,
    output logic                    o_was_extended,
    output logic [47:0]             o_source_address,
    output logic signed [7:0]       o_source_strength,
    output logic [7:0]              o_payload_length,
    output logic [31:0]             o_total_count,
    output logic [31:0]             o_match_count,
    output logic [31:0]             o_legacy_count,
    output logic [31:0]             o_extended_count
);

    localparam int CW = advrid_pkg::COUNT_WIDTH;

    logic                   r_valid;
    logic                   r_pay_sent;
    logic                   r_kind;
    logic [7:0]             r_pbyte;
    logic                   r_plast;
    logic                   r_found;
    logic                   r_ext;
    logic [47:0]            r_addr;
    logic signed [7:0]      r_rssi;
    logic [7:0]             r_plen;
    logic [CW-1:0]          r_total, r_match, r_legacy, r_extcnt;
    logic [CW-1:0]          n_total, n_match, n_legacy, n_extcnt;
    logic [63:0]            w_total, w_match, w_legacy, w_extcnt;

    logic load, load_pay, load_sum;

    always_comb begin
        load     = !i_q_stat.empty && (!r_valid || !i_stall);
        load_pay = load && i_head.has_pay && !r_pay_sent;
        load_sum = load && !load_pay;
        o_pop    = load && !(load_pay && i_head.has_sum);

        n_total  = r_total + 1'b1;
        n_match  = r_match;
        n_legacy = r_legacy;
        n_extcnt = r_extcnt;
        if (i_head.found) begin
            n_match = r_match + 1'b1;
            if (i_head.ext) begin
                n_extcnt = r_extcnt + 1'b1;
            end else begin
                n_legacy = r_legacy + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_pay_sent <= 1'b0;
            r_total    <= '0;
            r_match    <= '0;
            r_legacy   <= '0;
            r_extcnt   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
            if (load_pay) begin
                r_pay_sent <= i_head.has_sum;
            end else if (load_sum) begin
                r_pay_sent <= 1'b0;
            end
            if (load_sum) begin
                r_total  <= n_total;
                r_match  <= n_match;
                r_legacy <= n_legacy;
                r_extcnt <= n_extcnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_pay) begin
            r_kind  <= advrid_pkg::KIND_PAY;
            r_pbyte <= i_head.pay_byte;
            r_plast <= i_head.pay_last;
            r_found <= 1'b0;
            r_ext   <= 1'b0;
            r_addr  <= '0;
            r_rssi  <= '0;
            r_plen  <= '0;
        end else if (load_sum) begin
            r_kind  <= advrid_pkg::KIND_SUM;
            r_pbyte <= '0;
            r_plast <= 1'b0;
            r_found <= i_head.found;
            r_ext   <= i_head.ext;
            r_addr  <= i_head.addr;
            r_rssi  <= i_head.rssi;
            r_plen  <= i_head.plen;
        end
    end

    // counters are zero on payload beats
    assign w_total  = (r_kind == advrid_pkg::KIND_SUM) ? 64'(r_total)  : 64'd0;
    assign w_match  = (r_kind == advrid_pkg::KIND_SUM) ? 64'(r_match)  : 64'd0;
    assign w_legacy = (r_kind == advrid_pkg::KIND_SUM) ? 64'(r_legacy) : 64'd0;
    assign w_extcnt = (r_kind == advrid_pkg::KIND_SUM) ? 64'(r_extcnt) : 64'd0;

    assign o_valid           = r_valid;
    assign o_kind            = r_kind;
    assign o_payload_byte    = r_pbyte;
    assign o_payload_last    = r_plast;
    assign o_found           = r_found;
    assign o_was_extended    = r_ext;
    assign o_source_address  = r_addr;
    assign o_source_strength = r_rssi;
    assign o_payload_length  = r_plen;
    assign o_total_count     = w_total[31:0];
    assign o_match_count     = w_match[31:0];
    assign o_legacy_count    = w_legacy[31:0];
    assign o_extended_count  = w_extcnt[31:0];

    a_pay_sent_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pay_sent |-> !i_q_stat.empty)
        else $error("payload half sent but queue head gone");
    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_sum |=> (r_total == CW'($past(r_total) + 1'b1)))
        else $error("total counter did not step on summary");
    a_match_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !load_sum |=> (r_match == $past(r_match)) && (r_total == $past(r_total)))
        else $error("counter moved without a summary");

endmodule
`default_nettype wire

FILE: design/adv_remote_id_extractor.sv
// A result beat is written into the queue and then into the output register before it can be taken.
// A final byte that also carries a payload byte gives a payload beat followed by a summary beat.
// Throughput: one input beat per cycle; output drains one beat per cycle while i_stall is low, via a 4-entry queue.
// Input stalls only while that queue is full.
// Reset (synchronous, active low) clears the walk state, the four counters, the queue
// and the output valid.
`default_nettype none
module adv_remote_id_extractor (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire [7:0]           i_data_byte,
    input  wire                 i_start_of_adv,
    input  wire [7:0]           i_adv_length,
    input  wire                 i_is_extended,
    input  wire [47:0]          i_device_address,
    input  wire signed [7:0]    i_signal_strength,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic                o_kind,
    output logic [7:0]          o_payload_byte,
    output logic                o_payload_last,
    output logic                o_found,
    output logic                o_was_extended,
    output logic [47:0]         o_source_address,
    output logic signed [7:0]   o_source_strength,
    output logic [7:0]          o_payload_length,
    output logic [31:0]         o_total_count,
    output logic [31:0]         o_match_count,
    output logic [31:0]         o_legacy_count,
    output logic [31:0]         o_extended_count
);

    advrid_pkg::t_rec    push_rec, head_rec;
    advrid_pkg::t_q_stat q_stat;
    logic                push, pop, accept;

    assign o_stall = q_stat.full;
    assign accept  = i_valid && !q_stat.full;

    advrid_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_data_byte       (i_data_byte),
        .i_start_of_adv    (i_start_of_adv),
        .i_adv_length      (i_adv_length),
        .i_is_extended     (i_is_extended),
        .i_device_address  (i_device_address),
        .i_signal_strength (i_signal_strength),
        .o_push            (push),
        .o_rec             (push_rec)
    );

    advrid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_head  (head_rec),
        .o_stat  (q_stat)
    );

    advrid_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head_rec),
        .i_q_stat          (q_stat),
        .o_pop             (pop),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_kind            (o_kind),
        .o_payload_byte    (o_payload_byte),
        .o_payload_last    (o_payload_last),
        .o_found           (o_found),
        .o_was_extended    (o_was_extended),
        .o_source_address  (o_source_address),
        .o_source_strength (o_source_strength),
        .o_payload_length  (o_payload_length),
        .o_total_count     (o_total_count),
        .o_match_count     (o_match_count),
        .o_legacy_count    (o_legacy_count),
        .o_extended_count  (o_extended_count)
    );

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`default_nettype none
module tb_top;
    import advrid_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SHOW_LIMIT  = 10;
    localparam int TAIL_CYCLES = 4;

    // byte offsets inside one AD structure, counted from its length byte
    localparam int REL_TYPE    = 1;
    localparam int REL_ID_LO   = 2;
    localparam int REL_ID_HI   = 3;
    localparam int REL_APP     = 4;
    localparam int REL_PAYLOAD = 6;
    localparam int RID_HDR     = 5;

    typedef logic [7:0] octet_t;

    typedef struct packed {
        logic              sof;
        logic [7:0]        data;
        logic [7:0]        len;
        logic              ext;
        logic [47:0]       addr;
        logic signed [7:0] rssi;
    } adv_beat_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        pay_byte;
        logic              pay_last;
        logic              found;
        logic              ext;
        logic [47:0]       addr;
        logic signed [7:0] rssi;
        logic [7:0]        plen;
        logic [31:0]       total;
        logic [31:0]       matched;
        logic [31:0]       legacy;
        logic [31:0]       extended;
    } rid_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_data_byte = '0;
    logic               i_start_of_adv = 1'b0;
    logic [7:0]         i_adv_length = '0;
    logic               i_is_extended = 1'b0;
    logic [47:0]        i_device_address = '0;
    logic signed [7:0]  i_signal_strength = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_kind;
    logic [7:0]         o_payload_byte;
    logic               o_payload_last;
    logic               o_found;
    logic               o_was_extended;
    logic [47:0]        o_source_address;
    logic signed [7:0]  o_source_strength;
    logic [7:0]         o_payload_length;
    logic [31:0]        o_total_count;
    logic [31:0]        o_match_count;
    logic [31:0]        o_legacy_count;
    logic [31:0]        o_extended_count;

    adv_remote_id_extractor dut (.*);

    always #4 i_clk = ~i_clk;

    // scanner state as seen by the testbench
    logic [7:0]  walk_pos;
    logic [8:0]  walk_next;
    logic [7:0]  walk_flen;
    logic [7:0]  walk_ftype;
    logic [7:0]  walk_idlo;
    logic [1:0]  walk_phase;
    logic [7:0]  walk_mlen;
    logic [31:0] seen_total = '0;
    logic [31:0] seen_matched = '0;
    logic [31:0] seen_legacy = '0;
    logic [31:0] seen_extended = '0;

    rid_result_t pending_results[$];
    int          mismatches = 0;
    int          beats_sent = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          need_sof = 1'b0;

    function automatic void clear_walk();
        walk_pos   = '0;
        walk_next  = '0;
        walk_flen  = '0;
        walk_ftype = '0;
        walk_idlo  = '0;
        walk_phase = PH_SEARCH;
        walk_mlen  = '0;
    endfunction

    task automatic walk_adv_byte(input adv_beat_t bt);
        int          p;
        int          len;
        int          b;
        int          rel;
        int          id;
        bit          fin;
        bit          hit;
        rid_result_t r;
        if (bt.sof) clear_walk();
        p   = walk_pos;
        len = bt.len;
        b   = bt.data;
        fin = (len == 0) || (p + 1 >= len);
        if (len >= MIN_ADV && walk_phase != PH_STOP && walk_phase != PH_FOUND) begin
            if (walk_phase == PH_SEARCH && p == walk_next) begin
                if (p + 1 < len) begin
                    if (b == 0 || p + b >= len) begin
                        walk_phase = PH_STOP;
                    end else begin
                        walk_flen = 8'(b);
                        walk_next = 9'(p + b + 1);
                    end
                end
            end else if (p < walk_next) begin
                rel = (p - (int'(walk_next) - int'(walk_flen) - 1)) & 'h1FF;
                if (walk_phase == PH_SEARCH) begin
                    case (rel)
                        REL_TYPE:  walk_ftype = 8'(b);
                        REL_ID_LO: walk_idlo = 8'(b);
                        REL_ID_HI: begin
                            id = int'(walk_idlo) | (b << 8);
                            if (!(walk_flen >= 4 &&
                                  ((walk_ftype == TYPE_SVC16 && id == SVC_UUID) ||
                                   (walk_ftype == TYPE_MFG && id == MFR_ID))))
                                walk_ftype = '0;
                        end
                        REL_APP: begin
                            if (walk_ftype != 0 && walk_flen >= RID_HDR && b == RID_APP_ID) begin
                                walk_mlen  = walk_flen - 8'(RID_HDR);
                                walk_phase = (walk_mlen != 0) ? PH_STREAM : PH_FOUND;
                            end
                        end
                        default: ;
                    endcase
                end else if (rel >= REL_PAYLOAD && rel <= walk_flen) begin
                    r          = '0;
                    r.kind     = KIND_PAY;
                    r.pay_byte = 8'(b);
                    r.pay_last = (rel == walk_flen);
                    pending_results.push_back(r);
                    if (r.pay_last) walk_phase = PH_FOUND;
                end
            end
        end
        if (fin) begin
            hit = (len >= MIN_ADV) && (walk_phase == PH_STREAM || walk_phase == PH_FOUND);
            seen_total = seen_total + 1;
            if (hit) begin
                seen_matched = seen_matched + 1;
                if (bt.ext) seen_extended = seen_extended + 1;
                else seen_legacy = seen_legacy + 1;
            end
            r          = '0;
            r.kind     = KIND_SUM;
            r.found    = hit;
            r.ext      = bt.ext;
            r.addr     = bt.addr;
            r.rssi     = bt.rssi;
            r.plen     = hit ? walk_mlen : 8'd0;
            r.total    = seen_total;
            r.matched  = seen_matched;
            r.legacy   = seen_legacy;
            r.extended = seen_extended;
            pending_results.push_back(r);
            clear_walk();
        end else begin
            walk_pos = 8'(p + 1);
        end
    endtask

    // called right after a rising edge
    task automatic send_beat(input adv_beat_t bt);
        bit took;
        i_valid           <= 1'b1;
        i_data_byte       <= bt.data;
        i_start_of_adv    <= bt.sof;
        i_adv_length      <= bt.len;
        i_is_extended     <= bt.ext;
        i_device_address  <= bt.addr;
        i_signal_strength <= bt.rssi;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = !o_stall;
            @(posedge i_clk);
        end
        beats_sent++;
        walk_adv_byte(bt);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_advert(input octet_t body[$], input int len, input bit ext,
                               input logic [47:0] addr, input logic signed [7:0] rssi,
                               input bit sof, input int cut, input int shrink_at,
                               input int shrink_len);
        adv_beat_t bt;
        int        n;
        n = (len == 0) ? 1 : len;
        if (cut >= 0) n = cut;
        for (int i = 0; i < n; i++) begin
            bt.data = (i < body.size()) ? body[i] : 8'($urandom);
            bt.sof  = sof && (i == 0);
            bt.len  = (i == shrink_at) ? 8'(shrink_len) : 8'(len);
            bt.ext  = ext;
            bt.addr = addr;
            bt.rssi = rssi;
            send_beat(bt);
            if (i == shrink_at) break;
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic void add_filler(ref octet_t body[$]);
        int l;
        l = $urandom_range(1, 4);
        body.push_back(8'(l));
        repeat (l) body.push_back(8'($urandom));
    endfunction

    function automatic int add_rid_field(ref octet_t body[$], input int plen, input bit mfg);
        int at;
        at = body.size();
        body.push_back(8'(plen + RID_HDR));
        body.push_back(mfg ? TYPE_MFG : TYPE_SVC16);
        body.push_back(mfg ? MFR_ID[7:0] : SVC_UUID[7:0]);
        body.push_back(mfg ? MFR_ID[15:8] : SVC_UUID[15:8]);
        body.push_back(RID_APP_ID);
        body.push_back(8'($urandom));
        repeat (plen) body.push_back(8'($urandom));
        return at;
    endfunction

    task automatic send_random_advert();
        octet_t            body[$];
        int                pick;
        int                len;
        int                cut;
        int                shrink_at;
        int                shrink_len;
        int                plen;
        int                at;
        int                k;
        bit                sof;
        bit                ext;
        logic [47:0]       addr;
        logic signed [7:0] rssi;
        pick = $urandom_range(99);
        ext  = 1'($urandom_range(1));
        addr = {16'($urandom), 32'($urandom)};
        rssi = 8'($urandom);
        cut = -1;
        shrink_at = -1;
        shrink_len = 0;
        if (pick < 65) begin
            repeat ($urandom_range(2)) add_filler(body);
            plen = ($urandom_range(19) == 0) ? $urandom_range(120, 200) : $urandom_range(12);
            at = add_rid_field(body, plen, 1'($urandom_range(1)));
            if ($urandom_range(3) == 0) void'(add_rid_field(body, $urandom_range(6), 1'($urandom_range(1))));
            if ($urandom_range(3) == 0) add_filler(body);
            len = body.size() + $urandom_range(3);
            if (len > 255) len = 255;
            k = $urandom_range(9);
            if (k == 0) begin
                len = $urandom_range(6, len);
            end else if (k == 1) begin
                body[at + $urandom_range(REL_TYPE, REL_APP)] ^= 8'(1 << $urandom_range(7));
            end else if (k == 2) begin
                cut = $urandom_range(1, len - 1);
            end
        end else if (pick < 77) begin
            repeat ($urandom_range(2)) add_filler(body);
            k = body.size();
            body.push_back('0);
            void'(add_rid_field(body, $urandom_range(4), 1'($urandom_range(1))));
            len = body.size();
            body[k] = $urandom_range(1) ? 8'd0 : 8'($urandom_range(len - k, 255));
        end else if (pick < 85) begin
            if ($urandom_range(1)) void'(add_rid_field(body, 0, 1'($urandom_range(1))));
            len = $urandom_range(1, 5);
        end else if (pick < 90) begin
            len = 0;
        end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(41, 255) : $urandom_range(6, 40);
        end
        if (cut < 0 && len >= 2 && $urandom_range(19) == 0) begin
            shrink_at  = $urandom_range(len - 2);
            shrink_len = $urandom_range(shrink_at + 1);
        end
        sof = need_sof || ($urandom_range(4) != 0);
        need_sof = (cut >= 0);
        send_advert(body, len, ext, addr, rssi, sof, cut, shrink_at, shrink_len);
    endtask

    task automatic test_empty_advert();
        octet_t body[$];
        body = {8'hFF};
        send_advert(body, 0, 1'b1, '1, -8'sd128, 1'b1, -1, -1, 0);
    endtask

    // also checks that the walk restarts without a start flag
    task automatic test_empty_payload();
        octet_t body[$];
        body = {8'd5, TYPE_MFG, MFR_ID[7:0], MFR_ID[15:8], RID_APP_ID, 8'h80};
        send_advert(body, 6, 1'b0, '0, 8'sd127, 1'b0, -1, -1, 0);
    endtask

    task automatic test_start_flag();
        octet_t body[$];
        body = {8'd6, TYPE_SVC16, SVC_UUID[7:0], SVC_UUID[15:8], RID_APP_ID, 8'h01, 8'hA5};
        send_advert(body, 7, 1'b0, 48'h1234_5678_9ABC, 8'sd0, 1'b1, 1, -1, 0);
        // last payload byte lands on the final byte of the advert
        send_advert(body, 7, 1'b1, 48'hA5A5_5A5A_F00F, -8'sd1, 1'b1, -1, -1, 0);
    endtask

    task automatic test_truncated();
        octet_t body[$];
        body = {8'd8, TYPE_SVC16, SVC_UUID[7:0], SVC_UUID[15:8], RID_APP_ID, 8'h02,
                8'h00, 8'hFF};
        send_advert(body, 9, 1'b0, 48'h8000_0000_0001, -8'sd70, 1'b1, -1, 7, 8);
    endtask

    task automatic test_walk_stops();
        octet_t body[$];
        body = {8'd2, TYPE_MFG, 8'h00};
        send_advert(body, 3, 1'b0, 48'h0000_FFFF_0000, 8'sd42, 1'b1, -1, -1, 0);
        body = {8'd2, 8'h01, 8'h06, 8'h00, TYPE_SVC16, SVC_UUID[7:0]};
        send_advert(body, 6, 1'b1, 48'hFFFF_0000_FFFF, -8'sd42, 1'b0, -1, -1, 0);
    endtask

    task automatic test_random_traffic(input int beats, input int idle, input int stall);
        int target;
        send_idle_pct = idle;
        stall_pct     = stall;
        target        = beats_sent + beats;
        while (beats_sent < target) send_random_advert();
        drain();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(negedge i_clk) begin
        rid_result_t got;
        rid_result_t want;
        string       bad;
        if (i_rst_n && o_valid && !i_stall) begin
            got.kind     = o_kind;
            got.pay_byte = o_payload_byte;
            got.pay_last = o_payload_last;
            got.found    = o_found;
            got.ext      = o_was_extended;
            got.addr     = o_source_address;
            got.rssi     = o_source_strength;
            got.plen     = o_payload_length;
            got.total    = o_total_count;
            got.matched  = o_match_count;
            got.legacy   = o_legacy_count;
            got.extended = o_extended_count;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT) $display("unexpected result beat: %p", got);
            end else begin
                want = pending_results.pop_front();
                bad = "";
                if (got.kind !== want.kind) bad = {bad, " kind"};
                if (got.pay_byte !== want.pay_byte) bad = {bad, " payload_byte"};
                if (got.pay_last !== want.pay_last) bad = {bad, " payload_last"};
                if (got.found !== want.found) bad = {bad, " found"};
                if (got.ext !== want.ext) bad = {bad, " was_extended"};
                if (got.addr !== want.addr) bad = {bad, " source_address"};
                if (got.rssi !== want.rssi) bad = {bad, " source_strength"};
                if (got.plen !== want.plen) bad = {bad, " payload_length"};
                if (got.total !== want.total) bad = {bad, " total_count"};
                if (got.matched !== want.matched) bad = {bad, " match_count"};
                if (got.legacy !== want.legacy) bad = {bad, " legacy_count"};
                if (got.extended !== want.extended) bad = {bad, " extended_count"};
                if (bad != "") begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("mismatch in%s\n  expected %p\n  actual   %p", bad, want, got);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("adv_remote_id_extractor verification failed");
                $finish;
            end
        end
    end

    initial begin
        clear_walk();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_advert();
        test_empty_payload();
        test_start_flag();
        test_truncated();
        test_walk_stops();
        drain();
        test_random_traffic(350, 0, 0);
        test_random_traffic(350, 57, 0);
        test_random_traffic(350, 0, 57);
        test_random_traffic(350, 17, 17);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("adv_remote_id_extractor verification clean");
        end else begin
            $display("adv_remote_id_extractor verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
